// File: sv/fbba_pkg.sv
// ----------------------------------------------------------------------------
// fbba_pkg
// Shared types, constants and register codes of the fixed block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package fbba_pkg;

  // Build-time capacity default
  localparam int MAX_BLOCKS_DEF = 64;

  // Bitmap word organisation
  localparam int WORD_W = 32;
  localparam int BIT_W  = 5;   // bit select within a word
  localparam int IDX_W  = 7;   // live block index (count register is 7 bits)
  localparam int SW_W   = IDX_W - BIT_W; // word select of a live index

  // Field and arithmetic widths
  localparam int ADDR_W     = 32;
  localparam int SIZE_W     = 17;
  localparam int COUNT_W    = 7;
  localparam int STRIDE_W   = 18;
  localparam int PROD_W     = COUNT_W + STRIDE_W;
  localparam int OUT_IDX_W  = 6;
  localparam int STATUS_W   = 2;

  // Block layout: guard, payload, guard
  localparam logic [ADDR_W-1:0]   GUARD_BYTES    = 32'd4;
  localparam logic [STRIDE_W-1:0] BLOCK_OVERHEAD = 18'd8;

  // Configuration port
  localparam int APB_DATA_W = 32;
  localparam int CFG_ADDR_W = 4;

  localparam logic [ADDR_W-1:0]  HEAP_BASE_RST  = 32'd0;
  localparam logic [SIZE_W-1:0]  PAYLOAD_RST    = 17'd16;
  localparam logic [COUNT_W-1:0] BLOCK_CNT_RST  = 7'd64;

  typedef enum logic [1:0] {
    REG_HEAP_BASE    = 2'd0,
    REG_PAYLOAD_SIZE = 2'd1,
    REG_BLOCK_COUNT  = 2'd2
  } reg_idx_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_RANGE     = 2'd2,
    ST_NOT_ALLOC = 2'd3
  } status_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  heap_base;
    logic [SIZE_W-1:0]  payload_size;
    logic [COUNT_W-1:0] block_count;
  } cfg_t;

  typedef struct packed {
    logic rd;
    logic wr;
  } mem_ctrl_t;

endpackage

`default_nettype wire

// File: sv/fbba_regs.sv
// ----------------------------------------------------------------------------
// fbba_regs
// APB-style configuration registers: heap base, payload size, block count.
// ----------------------------------------------------------------------------
`default_nettype none

module fbba_regs (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [fbba_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire logic [fbba_pkg::APB_DATA_W-1:0]  pwdata,
  output logic      [fbba_pkg::APB_DATA_W-1:0]  prdata,
  output logic                                  pready,
  output fbba_pkg::cfg_t                        cfg
);

  fbba_pkg::reg_idx_t reg_sel;
  logic               wr_en;

  assign reg_sel = fbba_pkg::reg_idx_t'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // Register writes; an address past the list is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.heap_base    <= fbba_pkg::HEAP_BASE_RST;
      cfg.payload_size <= fbba_pkg::PAYLOAD_RST;
      cfg.block_count  <= fbba_pkg::BLOCK_CNT_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        fbba_pkg::REG_HEAP_BASE:    cfg.heap_base    <= pwdata;
        fbba_pkg::REG_PAYLOAD_SIZE: cfg.payload_size <= pwdata[fbba_pkg::SIZE_W-1:0];
        fbba_pkg::REG_BLOCK_COUNT:  cfg.block_count  <= pwdata[fbba_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Read-back
  always_comb begin
    unique case (reg_sel)
      fbba_pkg::REG_HEAP_BASE:    prdata = cfg.heap_base;
      fbba_pkg::REG_PAYLOAD_SIZE: prdata = 32'(cfg.payload_size);
      fbba_pkg::REG_BLOCK_COUNT:  prdata = 32'(cfg.block_count);
      default:                    prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: sv/fbba_bitmap_mem.sv
// ----------------------------------------------------------------------------
// fbba_bitmap_mem
// Allocation bitmap store: one-port synchronous RAM of 32-bit words with a
// valid flop per word so that a word never written reads as all free.
// ----------------------------------------------------------------------------
`default_nettype none

module fbba_bitmap_mem #(
  parameter int DEPTH = 2,
  localparam int WA_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire fbba_pkg::mem_ctrl_t           ctrl,
  input  wire logic [WA_W-1:0]               addr,
  input  wire logic [fbba_pkg::WORD_W-1:0]   wdata,
  output logic      [fbba_pkg::WORD_W-1:0]   rdata
);

  logic [fbba_pkg::WORD_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]            word_valid;
  logic [fbba_pkg::WORD_W-1:0] rdata_q;
  logic                        rvalid_q;

  // Storage array
  always_ff @(posedge clk) begin
    if (ctrl.wr) begin
      mem[addr] <= wdata;
    end
    if (ctrl.rd) begin
      rdata_q <= mem[addr];
    end
  end

  // Written-word flags, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= '0;
      rvalid_q   <= 1'b0;
    end else begin
      if (ctrl.wr) begin
        word_valid[addr] <= 1'b1;
      end
      if (ctrl.rd) begin
        rvalid_q <= word_valid[addr];
      end
    end
  end

  assign rdata = rvalid_q ? rdata_q : '0;

endmodule

`default_nettype wire

// File: sv/fbba_divider.sv
// ----------------------------------------------------------------------------
// fbba_divider
// Restoring divider, one quotient bit a cycle, for offset / stride.
// The caller guarantees the quotient fits in IDX_W bits.
// ----------------------------------------------------------------------------
`default_nettype none

module fbba_divider (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  input  wire logic [fbba_pkg::ADDR_W-1:0]     dividend,
  input  wire logic [fbba_pkg::STRIDE_W-1:0]   divisor,
  output logic                                 done,
  output logic      [fbba_pkg::IDX_W-1:0]      quotient
);

  localparam int CNT_W = $clog2(fbba_pkg::IDX_W);

  logic                          running;
  logic [CNT_W-1:0]              cnt;
  logic [fbba_pkg::ADDR_W-1:0]   rem;
  logic [fbba_pkg::STRIDE_W-1:0] dvsr;
  logic [fbba_pkg::ADDR_W-1:0]   trial;
  logic                          take;

  assign trial = 32'(dvsr) << cnt;
  assign take  = rem >= trial;

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= CNT_W'(fbba_pkg::IDX_W - 1);
      end else if (running) begin
        if (cnt == '0) begin
          running <= 1'b0;
          done    <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= dividend;
      dvsr     <= divisor;
      quotient <= '0;
    end else if (running) begin
      if (take) begin
        rem <= rem - trial;
      end
      quotient[cnt[CNT_W-1:0]] <= take;
    end
  end

endmodule

`default_nettype wire

// File: sv/fixed_block_bitmap_allocator_core.sv
// ----------------------------------------------------------------------------
// fixed_block_bitmap_allocator_core
// Fixed-size block allocator over a bitmap held in a synchronous RAM.
//
//  channel   signals                                   handshake
//  -------   ---------------------------------------   ---------------------
//  request   mode, free_address                        start && !busy
//  result    status, payload_address, block_index      done (one-cycle strobe)
//  config    psel penable pwrite paddr pwdata prdata   psel&&penable&&pwrite
//
// Allocate: per bitmap word scanned, a RAM read, then a test and write back;
// then the multiply and the address add. Free: offset and span, range check,
// the 7-step divider, then a RAM read and a bit test with write back.
// One request at a time; busy is high from acceptance until the result.
// Reset clears the bitmap through per-word valid flops, no clearing pass.
// The result strobe cannot be held off; the next request may start in the
// cycle of the strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_block_bitmap_allocator_core #(
  parameter int MAX_BLOCKS = fbba_pkg::MAX_BLOCKS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic                              mode,
  input  wire logic [fbba_pkg::ADDR_W-1:0]       free_address,
  output logic                                   done,
  output logic      [fbba_pkg::STATUS_W-1:0]     status,
  output logic      [fbba_pkg::ADDR_W-1:0]       payload_address,
  output logic      [fbba_pkg::OUT_IDX_W-1:0]    block_index,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [fbba_pkg::CFG_ADDR_W-1:0]   paddr,
  input  wire logic [fbba_pkg::APB_DATA_W-1:0]   pwdata,
  output logic      [fbba_pkg::APB_DATA_W-1:0]   prdata,
  output logic                                   pready
);

  localparam int NWORDS = (MAX_BLOCKS + fbba_pkg::WORD_W - 1) / fbba_pkg::WORD_W;
  localparam int WA_W   = (NWORDS > 1) ? $clog2(NWORDS) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_A_RD, S_A_CHK, S_A_MUL, S_A_ADD,
    S_F_SPAN, S_F_RNG, S_F_DIV, S_F_RD, S_F_TST
  } state_t;

  state_t                        state;
  fbba_pkg::cfg_t                cfg;
  fbba_pkg::mem_ctrl_t           mem_ctrl;
  logic [WA_W-1:0]               mem_addr;
  logic [fbba_pkg::WORD_W-1:0]   mem_wdata;
  logic [fbba_pkg::WORD_W-1:0]   mem_rdata;

  logic [fbba_pkg::ADDR_W-1:0]   addr_q;
  logic [fbba_pkg::ADDR_W-1:0]   off;
  logic [fbba_pkg::SW_W-1:0]     scan_word;
  logic [fbba_pkg::IDX_W-1:0]    idx;
  logic [fbba_pkg::PROD_W-1:0]   prod;

  logic [fbba_pkg::COUNT_W-1:0]  n_live;
  logic [fbba_pkg::COUNT_W-1:0]  n_minus1;
  logic [fbba_pkg::SW_W-1:0]     last_word;
  logic [fbba_pkg::STRIDE_W-1:0] stride;
  logic [fbba_pkg::COUNT_W-1:0]  mul_a;

  logic [fbba_pkg::WORD_W-1:0]   free_vec;
  logic                          hit;
  logic [fbba_pkg::BIT_W-1:0]    hit_bit;
  logic [fbba_pkg::WORD_W-1:0]   hit_mask;

  logic                          div_start;
  logic                          div_done;
  logic [fbba_pkg::IDX_W-1:0]    quo;
  logic [fbba_pkg::WORD_W-1:0]   quo_mask;
  logic                          quo_set;
  logic                          quo_in;

  // Configuration registers
  fbba_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Bitmap RAM
  fbba_bitmap_mem #(.DEPTH(NWORDS)) u_mem (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (mem_ctrl),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // Offset-to-index divider
  fbba_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (off - fbba_pkg::GUARD_BYTES),
    .divisor  (stride),
    .done     (div_done),
    .quotient (quo)
  );

  // Live block count, clamped to capacity, and stride
  always_comb begin
    if (32'(cfg.block_count) > 32'(MAX_BLOCKS)) begin
      n_live = fbba_pkg::COUNT_W'(MAX_BLOCKS);
    end else begin
      n_live = cfg.block_count;
    end
  end
  assign n_minus1  = n_live - 1'b1;
  assign last_word = n_minus1[fbba_pkg::IDX_W-1:fbba_pkg::BIT_W];
  assign stride    = {1'b0, cfg.payload_size} + fbba_pkg::BLOCK_OVERHEAD;
  assign mul_a     = (state == S_A_MUL) ? idx : n_live;

  // Lowest free live bit of the word just read
  always_comb begin
    for (int b = 0; b < fbba_pkg::WORD_W; b++) begin
      free_vec[b] = !mem_rdata[b] && ({scan_word, fbba_pkg::BIT_W'(b)} < n_live);
    end
    hit     = |free_vec;
    hit_bit = '0;
    for (int b = fbba_pkg::WORD_W - 1; b >= 0; b--) begin
      if (free_vec[b]) begin
        hit_bit = fbba_pkg::BIT_W'(b);
      end
    end
  end
  assign hit_mask = 32'(1) << hit_bit;

  // Bit addressed by a free request
  assign quo_mask = 32'(1) << quo[fbba_pkg::BIT_W-1:0];
  assign quo_set  = |(mem_rdata & quo_mask);
  assign quo_in   = quo < n_live;

  // RAM port control
  always_comb begin
    mem_ctrl  = '0;
    mem_addr  = WA_W'(scan_word);
    mem_wdata = mem_rdata | hit_mask;
    unique case (state)
      S_A_RD: begin
        mem_ctrl.rd = 1'b1;
      end
      S_A_CHK: begin
        mem_ctrl.wr = hit;
      end
      S_F_RD: begin
        mem_ctrl.rd = quo_in;
        mem_addr    = WA_W'(quo[fbba_pkg::IDX_W-1:fbba_pkg::BIT_W]);
      end
      S_F_TST: begin
        mem_ctrl.wr = quo_set;
        mem_addr    = WA_W'(quo[fbba_pkg::IDX_W-1:fbba_pkg::BIT_W]);
        mem_wdata   = mem_rdata & ~quo_mask;
      end
      default: ;
    endcase
  end

  assign div_start = (state == S_F_RNG) && (off >= fbba_pkg::GUARD_BYTES) &&
                     (off < 32'(prod));
  assign busy      = (state != S_IDLE);

  // Sequencer and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            addr_q    <= free_address;
            scan_word <= '0;
            state     <= mode ? S_F_SPAN : S_A_RD;
          end
        end
        S_A_RD: begin
          state <= S_A_CHK;
        end
        S_A_CHK: begin
          if (hit) begin
            idx   <= {scan_word, hit_bit};
            state <= S_A_MUL;
          end else if (n_live == '0 || scan_word == last_word) begin
            done            <= 1'b1;
            status          <= fbba_pkg::ST_FULL;
            payload_address <= '0;
            block_index     <= '0;
            state           <= S_IDLE;
          end else begin
            scan_word <= scan_word + 1'b1;
            state     <= S_A_RD;
          end
        end
        S_A_MUL: begin
          prod  <= fbba_pkg::PROD_W'(mul_a) * fbba_pkg::PROD_W'(stride);
          state <= S_A_ADD;
        end
        S_A_ADD: begin
          done            <= 1'b1;
          status          <= fbba_pkg::ST_OK;
          payload_address <= cfg.heap_base + 32'(prod) + fbba_pkg::GUARD_BYTES;
          block_index     <= idx[fbba_pkg::OUT_IDX_W-1:0];
          state           <= S_IDLE;
        end
        S_F_SPAN: begin
          off   <= addr_q - cfg.heap_base;
          prod  <= fbba_pkg::PROD_W'(mul_a) * fbba_pkg::PROD_W'(stride);
          state <= S_F_RNG;
        end
        S_F_RNG: begin
          if (div_start) begin
            state <= S_F_DIV;
          end else begin
            done            <= 1'b1;
            status          <= fbba_pkg::ST_RANGE;
            payload_address <= '0;
            block_index     <= '0;
            state           <= S_IDLE;
          end
        end
        S_F_DIV: begin
          if (div_done) begin
            state <= S_F_RD;
          end
        end
        S_F_RD: begin
          if (quo_in) begin
            state <= S_F_TST;
          end else begin
            done            <= 1'b1;
            status          <= fbba_pkg::ST_RANGE;
            payload_address <= '0;
            block_index     <= '0;
            state           <= S_IDLE;
          end
        end
        S_F_TST: begin
          done            <= 1'b1;
          status          <= quo_set ? fbba_pkg::ST_OK : fbba_pkg::ST_NOT_ALLOC;
          payload_address <= '0;
          block_index     <= quo[fbba_pkg::OUT_IDX_W-1:0];
          state           <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: sv/fbba_checker.sv
// ----------------------------------------------------------------------------
// fbba_checker
// Port-level checks of the allocator core, bound to the core module.
// ----------------------------------------------------------------------------
`default_nettype none

module fbba_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            start,
  input wire logic                            busy,
  input wire logic                            done,
  input wire logic [fbba_pkg::STATUS_W-1:0]   status,
  input wire logic [fbba_pkg::ADDR_W-1:0]     payload_address,
  input wire logic [fbba_pkg::OUT_IDX_W-1:0]  block_index
);

  // Accepted request makes the core busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("core not busy after request");

  // Result appears only as a request completes
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> (!busy && $past(busy)))
    else $error("result without a request in flight");

  // Result strobes never come back to back
  a_single_result: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("back-to-back results");

  // Only a successful allocate carries an address
  a_addr_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != fbba_pkg::ST_OK) |-> (payload_address == '0))
    else $error("address on a failed request");

  // Full and out-of-range report index zero
  a_index_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (status == fbba_pkg::ST_FULL || status == fbba_pkg::ST_RANGE))
      |-> (block_index == '0))
    else $error("index on full or out-of-range result");

endmodule

bind fixed_block_bitmap_allocator_core fbba_checker u_fbba_checker (
  .clk             (clk),
  .rst             (rst),
  .start           (start),
  .busy            (busy),
  .done            (done),
  .status          (status),
  .payload_address (payload_address),
  .block_index     (block_index)
);

`default_nettype wire

// File: verif/tb_fixed_block_bitmap_allocator_core.sv
// ----------------------------------------------------------------------------
// tb_fixed_block_bitmap_allocator_core
// Self-checking bench for the fixed block bitmap allocator. A shadow bitmap
// and shadow registers predict every allocate and free request; each result
// strobe is checked field by field against the oldest prediction. Directed
// tests cover the corner cases, then randomised phases run under a range of
// register settings with random gaps between requests.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_fixed_block_bitmap_allocator_core;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PHASES  = 13;
  localparam int PHASE_REQUESTS = 150;

  typedef struct {
    fbba_pkg::status_t                    status;
    logic [fbba_pkg::ADDR_W-1:0]          payload_address;
    logic [fbba_pkg::OUT_IDX_W-1:0]       block_index;
  } alloc_outcome_t;

  // DUT ports
  logic                              clk;
  logic                              rst;
  logic                              start;
  logic                              busy;
  logic                              mode;
  logic [fbba_pkg::ADDR_W-1:0]       free_address;
  logic                              done;
  logic [fbba_pkg::STATUS_W-1:0]     status;
  logic [fbba_pkg::ADDR_W-1:0]       payload_address;
  logic [fbba_pkg::OUT_IDX_W-1:0]    block_index;
  logic                              psel;
  logic                              penable;
  logic                              pwrite;
  logic [fbba_pkg::CFG_ADDR_W-1:0]   paddr;
  logic [fbba_pkg::APB_DATA_W-1:0]   pwdata;
  logic [fbba_pkg::APB_DATA_W-1:0]   prdata;
  logic                              pready;

  // Shadow state of the allocator
  logic [fbba_pkg::ADDR_W-1:0]       shadow_base;
  logic [fbba_pkg::SIZE_W-1:0]       shadow_size;
  logic [fbba_pkg::COUNT_W-1:0]      shadow_count;
  logic [63:0]                       shadow_map;

  alloc_outcome_t         expected_outcomes[$];
  int                     error_count;
  int                     quiet_cycles;
  bit                     no_idle;

  fixed_block_bitmap_allocator_core dut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .mode            (mode),
    .free_address    (free_address),
    .done            (done),
    .status          (status),
    .payload_address (payload_address),
    .block_index     (block_index),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // Clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow helpers
  function automatic int live_blocks();
    return (shadow_count > 7'd64) ? 64 : int'(shadow_count);
  endfunction

  function automatic logic [fbba_pkg::ADDR_W-1:0] stride_of();
    return fbba_pkg::ADDR_W'(shadow_size) + 32'd8;
  endfunction

  function automatic logic [fbba_pkg::ADDR_W-1:0] slot_address(input int idx);
    return shadow_base + fbba_pkg::ADDR_W'(idx) * stride_of() + 32'd4;
  endfunction

  function automatic int pick_allocated();
    int n;
    int s;
    int k;
    n = live_blocks();
    if (n == 0) return -1;
    s = $urandom_range(0, n - 1);
    for (k = 0; k < n; k++) begin
      if (shadow_map[(s + k) % n]) return (s + k) % n;
    end
    return -1;
  endfunction

  // Predict the outcome of one request and update the shadow bitmap
  task automatic predict_allocation(input logic req_mode,
                                    input logic [fbba_pkg::ADDR_W-1:0] addr,
                                    output alloc_outcome_t res);
    int n;
    int i;
    logic [fbba_pkg::ADDR_W-1:0] stride;
    logic [fbba_pkg::ADDR_W-1:0] off;
    logic [63:0]                 span;
    logic [fbba_pkg::ADDR_W-1:0] idx;
    n      = live_blocks();
    stride = stride_of();
    res.status          = fbba_pkg::ST_FULL;
    res.payload_address = '0;
    res.block_index     = '0;
    if (req_mode == 1'b0) begin
      // lowest clear bit among live blocks
      for (i = 0; i < n; i++) begin
        if (!shadow_map[i]) begin
          shadow_map[i]       = 1'b1;
          res.status          = fbba_pkg::ST_OK;
          res.payload_address = slot_address(i);
          res.block_index     = fbba_pkg::OUT_IDX_W'(i);
          break;
        end
      end
    end else begin
      off        = addr - shadow_base;
      span       = 64'(n) * 64'(stride);
      res.status = fbba_pkg::ST_RANGE;
      if (off >= 32'd4 && 64'(off) < span) begin
        idx = (off - 32'd4) / stride;
        if (idx < 32'(n)) begin
          res.block_index = idx[fbba_pkg::OUT_IDX_W-1:0];
          if (!shadow_map[idx[5:0]]) begin
            res.status = fbba_pkg::ST_NOT_ALLOC;
          end else begin
            shadow_map[idx[5:0]] = 1'b0;
            res.status           = fbba_pkg::ST_OK;
          end
        end
      end
    end
  endtask

  // Send one request and record its predicted outcome on acceptance
  task automatic send_request(input logic req_mode,
                              input logic [fbba_pkg::ADDR_W-1:0] addr);
    int gap;
    alloc_outcome_t res;
    gap = no_idle ? 0 : $urandom_range(0, 17);
    @(negedge clk);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    mode         = req_mode;
    free_address = addr;
    start        = 1'b1;
    do @(posedge clk); while (busy);
    predict_allocation(req_mode, addr, res);
    expected_outcomes.push_back(res);
  endtask

  // Drop start and wait for all outstanding results
  task automatic settle_requests();
    @(negedge clk);
    start = 1'b0;
    while (expected_outcomes.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  // APB write, only with the block idle
  task automatic write_register(input fbba_pkg::reg_idx_t which, input logic [31:0] value);
    settle_requests();
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = fbba_pkg::CFG_ADDR_W'({which, 2'b00});
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (which)
      fbba_pkg::REG_HEAP_BASE:    shadow_base  = value;
      fbba_pkg::REG_PAYLOAD_SIZE: shadow_size  = value[fbba_pkg::SIZE_W-1:0];
      fbba_pkg::REG_BLOCK_COUNT:  shadow_count = value[fbba_pkg::COUNT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic write_config(input logic [31:0] base, input logic [31:0] size,
                              input logic [31:0] count);
    write_register(fbba_pkg::REG_HEAP_BASE, base);
    write_register(fbba_pkg::REG_PAYLOAD_SIZE, size);
    write_register(fbba_pkg::REG_BLOCK_COUNT, count);
  endtask

  // Reset settings: allocate, double free, offsets, range edges
  task automatic test_reset_settings();
    send_request(1'b0, 32'hFFFF_FFFF);
    send_request(1'b0, 32'h0000_0000);
    send_request(1'b1, slot_address(1));
    send_request(1'b1, slot_address(1));
    send_request(1'b1, 32'd10);             // inside payload of block 0
    send_request(1'b1, 32'd0);              // below first guard
    send_request(1'b1, 32'd3);
    send_request(1'b1, 32'd1535);           // last byte of region
    send_request(1'b1, 32'd1536);           // exclusive end bound
    send_request(1'b1, 32'hFFFF_FFFF);
  endtask

  // Small counts: full, zero blocks, zero payload size
  task automatic test_full_and_empty();
    write_config(32'h0000_1000, 32'd0, 32'd2);
    send_request(1'b0, 32'h0);
    send_request(1'b0, 32'h0);
    send_request(1'b0, 32'h0);              // full
    send_request(1'b1, slot_address(1));
    write_register(fbba_pkg::REG_BLOCK_COUNT, 32'd0);
    send_request(1'b0, 32'h0);              // no blocks: full
    send_request(1'b1, 32'h0000_1004);      // no blocks: out of range
  endtask

  // Clamped count, wrapping addresses, requests beyond a shrunk count
  task automatic test_clamp_and_shrink();
    write_config(32'hFFFF_FFF0, 32'd131071, 32'd127);
    send_request(1'b0, 32'h0);
    write_register(fbba_pkg::REG_BLOCK_COUNT, 32'd1);
    send_request(1'b1, slot_address(1));    // block beyond count: out of range
    send_request(1'b0, 32'h0);              // only block 0, already used
    write_config(32'hFFFF_FFF0, 32'd65536, 32'd64);
    send_request(1'b1, slot_address(1));
    send_request(1'b1, slot_address(0));
    send_request(1'b1, slot_address(63) + 32'd65539);
  endtask

  // Randomised phases under varied settings
  task automatic test_random_phases();
    int p;
    int k;
    int sel;
    int n;
    int blk;
    logic [31:0] base;
    logic [31:0] size;
    logic [31:0] count;
    logic [fbba_pkg::ADDR_W-1:0] span_lo;
    for (p = 0; p < RANDOM_PHASES; p++) begin
      case ($urandom_range(0, 3))
        0:       base = 32'h0;
        1:       base = 32'hFFFF_FFFF;
        default: base = $urandom;
      endcase
      case ($urandom_range(0, 5))
        0:       size = 32'd0;
        1:       size = 32'd1;
        2:       size = 32'd65536;
        3:       size = 32'd131071;
        default: size = $urandom_range(1, 64);
      endcase
      case ($urandom_range(0, 6))
        0:       count = 32'd0;
        1:       count = 32'd1;
        2:       count = 32'd64;
        3:       count = $urandom_range(65, 127);
        default: count = $urandom_range(1, 64);
      endcase
      write_config(base, size, count);
      no_idle = ($urandom_range(0, 3) == 0);
      for (k = 0; k < PHASE_REQUESTS; k++) begin
        n   = live_blocks();
        sel = $urandom_range(0, 99);
        blk = pick_allocated();
        if (sel < 40 || (sel < 70 && blk < 0) || (sel < 80 && n == 0)) begin
          send_request(1'b0, $urandom);
        end else if (sel < 70) begin
          send_request(1'b1, slot_address(blk));
        end else if (sel < 80) begin
          send_request(1'b1, slot_address($urandom_range(0, n - 1)) +
                             fbba_pkg::ADDR_W'($urandom_range(0, int'(stride_of()) - 1)));
        end else if (sel < 88) begin
          // region edges
          span_lo = fbba_pkg::ADDR_W'(64'(n) * 64'(stride_of()));
          case ($urandom_range(0, 5))
            0:       send_request(1'b1, shadow_base);
            1:       send_request(1'b1, shadow_base + 32'd3);
            2:       send_request(1'b1, shadow_base + 32'd4);
            3:       send_request(1'b1, shadow_base + span_lo - 32'd1);
            4:       send_request(1'b1, shadow_base + span_lo);
            default: send_request(1'b1, shadow_base - 32'd1);
          endcase
        end else begin
          send_request(1'b1, $urandom);
        end
      end
      no_idle = 1'b0;
    end
  endtask

  // Result checker
  always @(posedge clk) begin
    alloc_outcome_t want;
    if (!rst && done) begin
      if (expected_outcomes.size() == 0) begin
        $display("%0t: unexpected result: status %0d, address %h, index %0d",
                 $time, status, payload_address, block_index);
        error_count++;
      end else begin
        want = expected_outcomes.pop_front();
        if (status !== want.status) begin
          $display("%0t: status mismatch: expected %0d, actual %0d",
                   $time, want.status, status);
          error_count++;
        end
        if (payload_address !== want.payload_address) begin
          $display("%0t: payload_address mismatch: expected %h, actual %h",
                   $time, want.payload_address, payload_address);
          error_count++;
        end
        if (block_index !== want.block_index) begin
          $display("%0t: block_index mismatch: expected %0d, actual %0d",
                   $time, want.block_index, block_index);
          error_count++;
        end
      end
    end
  end

  // Watchdog on cycles with no request, result or register write accepted
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (psel && penable && pwrite && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Test sequence
  initial begin
    clk          = 1'b0;
    rst          = 1'b1;
    start        = 1'b0;
    mode         = 1'b0;
    free_address = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    shadow_base  = fbba_pkg::HEAP_BASE_RST;
    shadow_size  = fbba_pkg::PAYLOAD_RST;
    shadow_count = fbba_pkg::BLOCK_CNT_RST;
    shadow_map   = '0;
    error_count  = 0;
    quiet_cycles = 0;
    no_idle      = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_settings();
    test_full_and_empty();
    test_clamp_and_shrink();
    test_random_phases();

    settle_requests();
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
